// ===== sv/lbhr_pkg.sv =====
// Shared types and constants for the header-rewriting load balancer.
// Used by lbhr_ctrl, lbhr_dp and lb_header_rewrite; no dependencies.
`default_nettype none

package lbhr_pkg;

  // Header layout (byte offsets within the frame)
  localparam int unsigned CntW = 6;
  localparam logic [CntW-1:0] HdrLen     = 6'd54;
  localparam logic [CntW-1:0] EthLen     = 6'd14;
  localparam logic [CntW-1:0] IpEnd      = 6'd34;
  localparam logic [CntW-1:0] DmacLoPos  = 6'd5;
  localparam logic [CntW-1:0] SmacLoPos  = 6'd11;
  localparam logic [CntW-1:0] EtypeHiPos = 6'd12;
  localparam logic [CntW-1:0] EtypeLoPos = 6'd13;
  localparam logic [CntW-1:0] ProtoPos   = 6'd23;
  localparam logic [CntW-1:0] CsumHiPos  = 6'd24;
  localparam logic [CntW-1:0] CsumLoPos  = 6'd25;
  localparam logic [CntW-1:0] SrcPos     = 6'd26;
  localparam logic [CntW-1:0] DstPos     = 6'd30;
  localparam logic [CntW-1:0] DportHiPos = 6'd36;
  localparam logic [CntW-1:0] DportLoPos = 6'd37;

  localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
  localparam logic [7:0]  ProtoTcp      = 8'd6;

  // Configuration register indexes
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] CfgNetPrefix   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgClientAddr  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgBackendA    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgBackendB    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgClientHost  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgBalancer    = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgServicePort = 3'd6;

  typedef enum logic [1:0] {
    VERDICT_ABORT = 2'd0,
    VERDICT_PASS  = 2'd1,
    VERDICT_TX    = 2'd2
  } verdict_e;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_DECIDE,
    ST_CSUM,
    ST_FOLD,
    ST_READ,
    ST_EMIT,
    ST_PASS
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic hdr_wr;    // store accepted header byte
    logic decide;    // register verdict and new destination host
    logic csum_add;  // add one rewritten address word to the checksum
    logic fold;      // fold and invert the checksum, restart flush index
    logic rd;        // read held byte at flush index
    logic emit;      // load rewritten held byte into the output register
    logic pass;      // load accepted byte straight into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hdr_end;     // byte being stored is the last header byte
    logic csum_last;   // final address word is being added
    logic flush_last;  // byte being emitted is the last held one
    logic frame_last;  // held bytes end the frame
    logic out_free;    // output register can take an item this cycle
  } sts_t;

endpackage

`default_nettype wire

// ===== sv/lbhr_ctrl.sv =====
// Sequencer for the load balancer: header collection, decision, checksum,
// flush and pass-through. Depends on lbhr_pkg.
`default_nettype none

module lbhr_ctrl import lbhr_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  input  wire  in_last_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic in_stall_o
);

  state_e state_q, state_d;
  logic   in_acc;

  always_comb begin
    in_stall_o = !((state_q == ST_COLLECT) || ((state_q == ST_PASS) && sts_i.out_free));
  end

  assign in_acc = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_COLLECT: begin
        if (in_acc && (in_last_i || sts_i.hdr_end)) state_d = ST_DECIDE;
      end
      ST_DECIDE: state_d = ST_CSUM;
      ST_CSUM: begin
        if (sts_i.csum_last) state_d = ST_FOLD;
      end
      ST_FOLD: state_d = ST_READ;
      ST_READ: state_d = ST_EMIT;
      ST_EMIT: begin
        if (sts_i.out_free) begin
          if (!sts_i.flush_last) state_d = ST_READ;
          else if (sts_i.frame_last) state_d = ST_COLLECT;
          else state_d = ST_PASS;
        end
      end
      ST_PASS: begin
        if (in_acc && in_last_i) state_d = ST_COLLECT;
      end
      default: state_d = ST_COLLECT;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_COLLECT: cmd_o.hdr_wr   = in_acc;
      ST_DECIDE:  cmd_o.decide   = 1'b1;
      ST_CSUM:    cmd_o.csum_add = 1'b1;
      ST_FOLD:    cmd_o.fold     = 1'b1;
      ST_READ:    cmd_o.rd       = 1'b1;
      ST_EMIT:    cmd_o.emit     = sts_i.out_free;
      ST_PASS:    cmd_o.pass     = in_acc;
      default:    cmd_o          = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COLLECT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/lbhr_dp.sv =====
// Datapath for the load balancer: configuration registers, header memory,
// field capture, verdict, checksum and output register. Depends on lbhr_pkg.
`default_nettype none

module lbhr_dp import lbhr_pkg::*; (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire [CfgIdxW-1:0]   cfg_idx_i,
  input  wire [CfgDataW-1:0]  cfg_data_i,
  input  wire [7:0]           in_byte_i,
  input  wire                 in_last_i,
  input  wire                 pick_second_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  wire                 out_stall_i,
  output logic                out_valid_o,
  output logic [7:0]          out_byte_o,
  output logic                out_last_o,
  output logic [1:0]          verdict_o
);

  // Configuration
  logic [23:0] net_prefix_q;
  logic [31:0] client_addr_q;
  logic [7:0]  backend_a_q, backend_b_q, client_host_q, balancer_q;
  logic [15:0] service_port_q;

  // Frame state
  logic [CntW-1:0] cnt_q, fl_idx_q;
  logic            frame_last_q, chosen_q;
  logic [15:0]     etype_q, dport_q, csum_q;
  logic [7:0]      proto_q, prev_q, host_q, host_d, rd_q;
  logic [31:0]     src_q;
  logic [19:0]     acc_q;
  logic [1:0]      step_q;
  verdict_e        verdict_q, verdict_d;
  logic [7:0]      hdr_mem_q [HdrLen];

  // Output register
  logic            out_valid_q, out_last_q;
  logic [7:0]      out_byte_q;
  verdict_e        out_verdict_q;

  logic            out_free, flush_last, is_req, is_rep, csum_pair;
  logic [15:0]     csum_word, fold2;
  logic [16:0]     fold1;
  logic [7:0]      emit_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      net_prefix_q   <= 24'd12587264;
      client_addr_q  <= 32'd3222339588;
      backend_a_q    <= 8'd2;
      backend_b_q    <= 8'd3;
      client_host_q  <= 8'd4;
      balancer_q     <= 8'd5;
      service_port_q <= 16'd80;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgNetPrefix:   net_prefix_q   <= cfg_data_i[23:0];
        CfgClientAddr:  client_addr_q  <= cfg_data_i;
        CfgBackendA:    backend_a_q    <= cfg_data_i[7:0];
        CfgBackendB:    backend_b_q    <= cfg_data_i[7:0];
        CfgClientHost:  client_host_q  <= cfg_data_i[7:0];
        CfgBalancer:    balancer_q     <= cfg_data_i[7:0];
        CfgServicePort: service_port_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Header memory: one write port, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.hdr_wr) hdr_mem_q[cnt_q] <= in_byte_i;
    if (cmd_i.rd) rd_q <= hdr_mem_q[fl_idx_q];
  end

  // Capture the fields the decision needs as they go by
  always_ff @(posedge clk_i) begin
    if (cmd_i.hdr_wr) begin
      prev_q <= in_byte_i;
      case (cnt_q)
        EtypeHiPos:        etype_q[15:8] <= in_byte_i;
        EtypeLoPos:        etype_q[7:0]  <= in_byte_i;
        ProtoPos:          proto_q       <= in_byte_i;
        SrcPos:            src_q[31:24]  <= in_byte_i;
        SrcPos + 6'd1:     src_q[23:16]  <= in_byte_i;
        SrcPos + 6'd2:     src_q[15:8]   <= in_byte_i;
        SrcPos + 6'd3:     src_q[7:0]    <= in_byte_i;
        DportHiPos:        dport_q[15:8] <= in_byte_i;
        DportLoPos:        dport_q[7:0]  <= in_byte_i;
        default: ;
      endcase
    end
  end

  // Odd byte of an IPv4 header word ahead of the checksum field
  assign csum_pair = (cnt_q > EthLen) && (cnt_q < CsumHiPos) && cnt_q[0];

  always_comb begin
    case (step_q)
      2'd0:    csum_word = net_prefix_q[23:8];
      2'd1:    csum_word = {net_prefix_q[7:0], balancer_q};
      2'd2:    csum_word = net_prefix_q[23:8];
      default: csum_word = {net_prefix_q[7:0], host_q};
    endcase
  end

  assign fold1 = {1'b0, acc_q[15:0]} + {13'b0, acc_q[19:16]};
  assign fold2 = fold1[15:0] + {15'b0, fold1[16]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.hdr_wr && (cnt_q == '0)) begin
      acc_q <= '0;
    end else if (cmd_i.hdr_wr && csum_pair) begin
      acc_q <= acc_q + {4'b0, prev_q, in_byte_i};
    end else if (cmd_i.csum_add) begin
      acc_q <= acc_q + {4'b0, csum_word};
    end
    if (cmd_i.decide) step_q <= '0;
    else if (cmd_i.csum_add) step_q <= step_q + 2'd1;
    if (cmd_i.fold) csum_q <= ~fold2;
    if (cmd_i.hdr_wr) frame_last_q <= in_last_i;
    if (cmd_i.decide) host_q <= host_d;
  end

  // Verdict
  assign is_req = (src_q == client_addr_q) && (dport_q == service_port_q);
  assign is_rep = (src_q == {net_prefix_q, backend_a_q}) ||
                  (src_q == {net_prefix_q, backend_b_q});

  always_comb begin
    host_d = client_host_q;
    if (cnt_q < EthLen) verdict_d = VERDICT_ABORT;
    else if (etype_q != EtherTypeIpv4) verdict_d = VERDICT_PASS;
    else if (cnt_q < IpEnd) verdict_d = VERDICT_ABORT;
    else if (proto_q != ProtoTcp) verdict_d = VERDICT_PASS;
    else if (cnt_q < HdrLen) verdict_d = VERDICT_ABORT;
    else if (is_req) begin
      verdict_d = VERDICT_TX;
      host_d    = chosen_q ? backend_b_q : backend_a_q;
    end else if (is_rep) verdict_d = VERDICT_TX;
    else verdict_d = VERDICT_PASS;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      fl_idx_q  <= '0;
      chosen_q  <= 1'b0;
      verdict_q <= VERDICT_ABORT;
    end else begin
      if (cmd_i.hdr_wr) cnt_q <= cnt_q + 6'd1;
      else if (cmd_i.emit && flush_last) cnt_q <= '0;
      if (cmd_i.hdr_wr && (cnt_q == '0)) chosen_q <= pick_second_i;
      if (cmd_i.decide) verdict_q <= verdict_d;
      if (cmd_i.fold) fl_idx_q <= '0;
      else if (cmd_i.emit) fl_idx_q <= fl_idx_q + 6'd1;
    end
  end

  assign flush_last = (fl_idx_q + 6'd1) == cnt_q;

  // Overlay rewritten fields on the held header
  always_comb begin
    emit_byte = rd_q;
    if (verdict_q == VERDICT_TX) begin
      case (fl_idx_q)
        DmacLoPos:     emit_byte = host_q;
        SmacLoPos:     emit_byte = balancer_q;
        CsumHiPos:     emit_byte = csum_q[15:8];
        CsumLoPos:     emit_byte = csum_q[7:0];
        SrcPos:        emit_byte = net_prefix_q[23:16];
        SrcPos + 6'd1: emit_byte = net_prefix_q[15:8];
        SrcPos + 6'd2: emit_byte = net_prefix_q[7:0];
        SrcPos + 6'd3: emit_byte = balancer_q;
        DstPos:        emit_byte = net_prefix_q[23:16];
        DstPos + 6'd1: emit_byte = net_prefix_q[15:8];
        DstPos + 6'd2: emit_byte = net_prefix_q[7:0];
        DstPos + 6'd3: emit_byte = host_q;
        default:       emit_byte = rd_q;
      endcase
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit || cmd_i.pass) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_byte_q    <= emit_byte;
      out_last_q    <= frame_last_q && flush_last;
      out_verdict_q <= verdict_q;
    end else if (cmd_i.pass) begin
      out_byte_q    <= in_byte_i;
      out_last_q    <= in_last_i;
      out_verdict_q <= verdict_q;
    end
  end

  always_comb begin
    sts_o.hdr_end    = (cnt_q == HdrLen - 6'd1);
    sts_o.csum_last  = (step_q == 2'd3);
    sts_o.flush_last = flush_last;
    sts_o.frame_last = frame_last_q;
    sts_o.out_free   = out_free;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign verdict_o   = out_verdict_q;

endmodule

`default_nettype wire

// ===== sv/lb_header_rewrite.sv =====
// Two-backend NAT load balancer on an Ethernet byte stream.
// Top level: joins lbhr_ctrl and lbhr_dp. Depends on lbhr_pkg.
//
// Header bytes (up to 54, or fewer if the frame ends early) are taken one
// per cycle into a header memory, even while the output register still holds
// the previous frame's final item. The verdict is then registered, and the
// IPv4 checksum of the rewritten header is summed and folded; each held byte
// is then read from the header memory and loaded into the output register,
// once it is free, before the next one is read; the input stalls until the
// flush ends. Bytes after the header pass through the output register at
// one per cycle while the output is not stalled.
// Every byte of a frame carries the same verdict; aborted frames are still
// emitted unchanged.
`default_nettype none

module lb_header_rewrite import lbhr_pkg::*; (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire [CfgIdxW-1:0]  cfg_idx_i,
  input  wire [CfgDataW-1:0] cfg_data_i,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire [7:0]          in_byte_i,
  input  wire                in_last_i,
  input  wire                pick_second_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic [7:0]         out_byte_o,
  output logic               out_last_o,
  output logic [1:0]         verdict_o
);

  cmd_t cmd;
  sts_t sts;

  lbhr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_last_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  lbhr_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_byte_i     (in_byte_i),
    .in_last_i     (in_last_i),
    .pick_second_i (pick_second_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .out_byte_o    (out_byte_o),
    .out_last_o    (out_last_o),
    .verdict_o     (verdict_o)
  );

endmodule

`default_nettype wire
